// ===== rtl/touch_sample_conditioner_unit_assert.svh =====
// assertion macros shared by the touch sample conditioner rtl
`ifndef TOUCH_SAMPLE_CONDITIONER_UNIT_ASSERT_SVH
`define TOUCH_SAMPLE_CONDITIONER_UNIT_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define TSCOND_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tscond assertion failed");

// next-cycle implication under synchronous active-low reset
`define TSCOND_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tscond assertion failed");

`endif

// ===== rtl/tscond_pkg.sv =====
// shared types, constants and control structs of the touch sample conditioner
package tscond_pkg;

    localparam int CoordW     = 12;
    localparam int PressW     = 9;
    localparam int PlateW     = 16;
    localparam int TimerW     = 16;
    localparam int ProdW      = 32;
    localparam int DivSteps   = ProdW;
    localparam int DivCntW    = $clog2(DivSteps);
    localparam int RoundShift = 12;
    localparam int RoundBias  = 2047;
    localparam int PressMax   = 511;
    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 16;
    localparam int ReduceSh   = 4;

    localparam logic [CoordW-1:0] CoordMax      = {CoordW{1'b1}};
    localparam logic [TimerW-1:0] ReleaseTicksRst = TimerW'(50);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SWAP_AXES     = 3'd0,
        CFG_FLIP_X        = 3'd1,
        CFG_FLIP_Y        = 3'd2,
        CFG_REDUCE_8BIT   = 3'd3,
        CFG_PLATE_RES     = 3'd4,
        CFG_RELEASE_TICKS = 3'd5
    } t_cfg_reg;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_TICK   = 1'b1
    } t_req;

    typedef struct packed {
        logic              req_type;
        logic              pen_is_down;
        logic              x_ready;
        logic              y_ready;
        logic              z1_ready;
        logic              z2_ready;
        logic [CoordW-1:0] x_sample;
        logic [CoordW-1:0] y_sample;
        logic [CoordW-1:0] z1_sample;
        logic [CoordW-1:0] z2_sample;
    } t_in_word;

    typedef struct packed {
        logic              touch_state;
        logic              touch_changed;
        logic              axis_x_valid;
        logic [CoordW-1:0] axis_x_value;
        logic              axis_y_valid;
        logic [CoordW-1:0] axis_y_value;
        logic              pressure_valid;
        logic [PressW-1:0] pressure_value;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_ROUND,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic mul1;
        logic mul2;
        logic div_step;
        logic round;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic need_press;
        logic base_any;
        logic div_last;
        logic press_ok;
        logic res_any;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/tscond_in_if.sv =====
// input channel interface carrying one touch request word
interface tscond_in_if;
    logic                 valid;
    logic                 ready;
    tscond_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tscond_out_if.sv =====
// output channel interface carrying one touch report word
interface tscond_out_if;
    logic                  valid;
    logic                  ready;
    tscond_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tscond_ctrl.sv =====
// controller state machine sequencing load, multiply, divide, round and push
module tscond_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tscond_pkg::t_status i_status,
    output tscond_pkg::t_cmd    o_cmd
);

    tscond_pkg::t_state r_state;
    tscond_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tscond_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tscond_pkg::ST_IDLE: begin
                if (i_status.in_valid) begin
                    if (i_status.need_press) begin
                        n_state = tscond_pkg::ST_MUL1;
                    end else if (i_status.base_any) begin
                        n_state = tscond_pkg::ST_PUSH;
                    end
                end
            end
            tscond_pkg::ST_MUL1: n_state = tscond_pkg::ST_MUL2;
            tscond_pkg::ST_MUL2: n_state = tscond_pkg::ST_DIV;
            tscond_pkg::ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = tscond_pkg::ST_ROUND;
                end
            end
            tscond_pkg::ST_ROUND: begin
                if (i_status.press_ok || i_status.res_any) begin
                    n_state = tscond_pkg::ST_PUSH;
                end else begin
                    n_state = tscond_pkg::ST_IDLE;
                end
            end
            tscond_pkg::ST_PUSH: begin
                if (i_status.out_free) begin
                    n_state = tscond_pkg::ST_IDLE;
                end
            end
            default: n_state = tscond_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            tscond_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.load     = i_status.in_valid;
            end
            tscond_pkg::ST_MUL1:  o_cmd.mul1     = 1'b1;
            tscond_pkg::ST_MUL2:  o_cmd.mul2     = 1'b1;
            tscond_pkg::ST_DIV:   o_cmd.div_step = 1'b1;
            tscond_pkg::ST_ROUND: o_cmd.round    = 1'b1;
            tscond_pkg::ST_PUSH:  o_cmd.push     = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/tscond_datapath.sv =====
// datapath: config, pen and timer state, axis mapping, pressure unit, output register
module tscond_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tscond_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [tscond_pkg::CfgDataW-1:0] i_cfg_data,
    input  tscond_pkg::t_in_word            i_in_data,
    input  logic                            i_in_valid,
    input  logic                            i_out_ready,
    input  tscond_pkg::t_cmd                i_cmd,
    output tscond_pkg::t_status             o_status,
    output logic                            o_out_valid,
    output tscond_pkg::t_out_word           o_out_data
);

    localparam int CW = tscond_pkg::CoordW;
    localparam int PW = tscond_pkg::ProdW;
    localparam int QW = PW - tscond_pkg::RoundShift;

    // configuration
    logic                          r_swap;
    logic                          r_flip_x;
    logic                          r_flip_y;
    logic                          r_reduce;
    logic [tscond_pkg::PlateW-1:0] r_plate;
    logic [tscond_pkg::TimerW-1:0] r_rel_ticks;

    // pen state
    logic                          r_pen_down;
    logic [tscond_pkg::TimerW-1:0] r_timer;
    logic                          r_armed;

    // pressure unit
    logic [PW-1:0]                 r_prod;
    logic [CW-1:0]                 r_x;
    logic [CW-1:0]                 r_z1;
    logic [CW-1:0]                 r_rem;
    logic [tscond_pkg::DivCntW-1:0] r_cnt;

    // pending and output words
    tscond_pkg::t_out_word         r_res;
    logic                          r_any;
    tscond_pkg::t_out_word         r_out;
    logic                          r_out_vld;

    function automatic logic [CW-1:0] axis_map(input logic [CW-1:0] v, input logic flip,
                                               input logic reduce);
        logic [CW-1:0] r;
        r = flip ? (tscond_pkg::CoordMax - v) : v;
        if (reduce) begin
            r = r >> tscond_pkg::ReduceSh;
        end
        return r;
    endfunction

    logic                  is_tick;
    logic [CW-1:0]         xs;
    logic [CW-1:0]         ys;
    logic [CW-1:0]         vx;
    logic [CW-1:0]         vy;
    logic                  expire;
    logic                  smp_any;
    tscond_pkg::t_out_word smp_word;
    tscond_pkg::t_out_word exp_word;
    logic [PW-1:0]         diff;
    logic [CW+PW-1:0]      mul1_full;
    logic [tscond_pkg::PlateW+PW-1:0] mul2_full;
    logic [CW:0]           trial;
    logic [CW:0]           trial_sub;
    logic                  trial_ge;
    logic [PW-1:0]         rnd_sum;
    logic [QW-1:0]         p_val;
    logic                  p_ok;
    logic [tscond_pkg::PressW-1:0] p_out;

    assign is_tick = (i_in_data.req_type == tscond_pkg::REQ_TICK);
    assign xs      = i_in_data.x_ready ? i_in_data.x_sample : '0;
    assign ys      = i_in_data.y_ready ? i_in_data.y_sample : '0;
    assign vx      = axis_map(xs, r_swap ? r_flip_y : r_flip_x, r_reduce);
    assign vy      = axis_map(ys, r_swap ? r_flip_x : r_flip_y, r_reduce);
    assign expire  = r_armed && (r_timer <= tscond_pkg::TimerW'(1));
    assign smp_any = (i_in_data.pen_is_down != r_pen_down) || i_in_data.x_ready
                     || i_in_data.y_ready;

    always_comb begin
        smp_word               = '0;
        smp_word.touch_state   = i_in_data.pen_is_down;
        smp_word.touch_changed = (i_in_data.pen_is_down != r_pen_down);
        if (r_swap) begin
            smp_word.axis_y_valid = i_in_data.x_ready;
            smp_word.axis_y_value = i_in_data.x_ready ? vx : '0;
            smp_word.axis_x_valid = i_in_data.y_ready;
            smp_word.axis_x_value = i_in_data.y_ready ? vy : '0;
        end else begin
            smp_word.axis_x_valid = i_in_data.x_ready;
            smp_word.axis_x_value = i_in_data.x_ready ? vx : '0;
            smp_word.axis_y_valid = i_in_data.y_ready;
            smp_word.axis_y_value = i_in_data.y_ready ? vy : '0;
        end
        exp_word                = '0;
        exp_word.touch_changed  = 1'b1;
        exp_word.pressure_valid = 1'b1;
    end

    // 32-bit wrapping difference, then two truncated products
    assign diff      = PW'(i_in_data.z2_sample) - PW'(i_in_data.z1_sample);
    assign mul1_full = r_prod * r_x;
    assign mul2_full = r_prod * r_plate;

    // restoring divide, one quotient bit per cycle shifted into r_prod
    assign trial     = {r_rem, r_prod[PW-1]};
    assign trial_sub = trial - {1'b0, r_z1};
    assign trial_ge  = (trial >= {1'b0, r_z1});

    assign rnd_sum = r_prod + PW'(tscond_pkg::RoundBias);
    assign p_val   = rnd_sum[PW-1:tscond_pkg::RoundShift];
    assign p_ok    = (p_val < QW'(tscond_pkg::PressMax + 1));
    assign p_out   = tscond_pkg::PressW'(tscond_pkg::PressMax) - p_val[tscond_pkg::PressW-1:0];

    always_comb begin
        o_status            = '0;
        o_status.in_valid   = i_in_valid;
        o_status.need_press = !is_tick && i_in_data.x_ready && i_in_data.z1_ready
                              && i_in_data.z2_ready && (i_in_data.x_sample != '0)
                              && (i_in_data.z1_sample != '0);
        o_status.base_any   = is_tick ? expire : smp_any;
        o_status.div_last   = (r_cnt == tscond_pkg::DivCntW'(tscond_pkg::DivSteps - 1));
        o_status.press_ok   = p_ok;
        o_status.res_any    = r_any;
        o_status.out_free   = !r_out_vld || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap      <= 1'b0;
            r_flip_x    <= 1'b0;
            r_flip_y    <= 1'b0;
            r_reduce    <= 1'b1;
            r_plate     <= '0;
            r_rel_ticks <= tscond_pkg::ReleaseTicksRst;
        end else if (i_cfg_we) begin
            unique case (tscond_pkg::t_cfg_reg'(i_cfg_idx))
                tscond_pkg::CFG_SWAP_AXES:     r_swap      <= i_cfg_data[0];
                tscond_pkg::CFG_FLIP_X:        r_flip_x    <= i_cfg_data[0];
                tscond_pkg::CFG_FLIP_Y:        r_flip_y    <= i_cfg_data[0];
                tscond_pkg::CFG_REDUCE_8BIT:   r_reduce    <= i_cfg_data[0];
                tscond_pkg::CFG_PLATE_RES:     r_plate     <= i_cfg_data[tscond_pkg::PlateW-1:0];
                tscond_pkg::CFG_RELEASE_TICKS: r_rel_ticks <= i_cfg_data[tscond_pkg::TimerW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_down <= 1'b0;
            r_timer    <= '0;
            r_armed    <= 1'b0;
        end else if (i_cmd.load) begin
            if (is_tick) begin
                if (r_armed) begin
                    if (expire) begin
                        r_timer    <= '0;
                        r_armed    <= 1'b0;
                        r_pen_down <= 1'b0;
                    end else begin
                        r_timer <= r_timer - tscond_pkg::TimerW'(1);
                    end
                end
            end else begin
                r_pen_down <= i_in_data.pen_is_down;
                r_armed    <= i_in_data.pen_is_down;
                r_timer    <= i_in_data.pen_is_down ? r_rel_ticks : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prod <= diff;
            r_x    <= i_in_data.x_sample;
            r_z1   <= i_in_data.z1_sample;
            r_res  <= is_tick ? exp_word : smp_word;
        end else if (i_cmd.mul1) begin
            r_prod <= mul1_full[PW-1:0];
        end else if (i_cmd.mul2) begin
            r_prod <= mul2_full[PW-1:0];
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_prod <= {r_prod[PW-2:0], trial_ge};
            r_rem  <= trial_ge ? trial_sub[CW-1:0] : trial[CW-1:0];
        end else if (i_cmd.round) begin
            r_res.pressure_valid <= p_ok;
            r_res.pressure_value <= p_ok ? p_out : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_any <= is_tick ? expire : smp_any;
            end else if (i_cmd.round) begin
                r_any <= r_any || p_ok;
            end
            if (i_cmd.mul2) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + tscond_pkg::DivCntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/touch_sample_conditioner_unit.sv =====
// top level of the touch sample conditioner: controller, datapath and assertions
//
//  channel   dir  handshake      word
//  i_in      in   valid/ready    tscond_pkg::t_in_word (sample event or tick)
//  o_out     out  valid/ready    tscond_pkg::t_out_word (touch report)
//  i_cfg_*   in   write enable   register index and 16-bit data
//
// tick, or sample without full pressure data: accepted in idle, posted from push if it reports
// sample with pressure: MUL1, MUL2, the 32-step restoring divider and ROUND, then PUSH
//   if the word reports anything; the push state waits until the output register is free
// reset is synchronous, active low; config takes its reset values, no clearing pass
// a finished word waits in the output register while the next word is accepted;
//   a second word waits in the push state until the output register frees up
module touch_sample_conditioner_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tscond_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [tscond_pkg::CfgDataW-1:0] i_cfg_data,
    tscond_in_if.sink                       i_in,
    tscond_out_if.source                    o_out
);

    tscond_pkg::t_cmd    cmd;
    tscond_pkg::t_status status;

    tscond_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    tscond_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in.data),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.data)
    );

    assign i_in.ready = cmd.in_ready;

`include "touch_sample_conditioner_unit_assert.svh"

    // a word that needs the pressure unit blocks the input on the next cycle
    `TSCOND_ASSERT_NEXT(a_press_blocks_in, i_clk, i_rst_n, cmd.load && status.need_press, !i_in.ready)
    // a push always leaves a valid word in the output register
    `TSCOND_ASSERT_NEXT(a_push_fills_out, i_clk, i_rst_n, cmd.push, o_out.valid)
    // a word with nothing to report returns straight to accepting
    `TSCOND_ASSERT_NEXT(a_silent_idle, i_clk, i_rst_n, cmd.load && !status.need_press && !status.base_any, i_in.ready)
    // the divider is only stepped while a pressure word is in flight
    `TSCOND_ASSERT_NOW(a_div_no_in, i_clk, i_rst_n, cmd.div_step, !i_in.ready && !cmd.push)

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench of the touch sample conditioner: predictor, driver, monitor
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned HoldAt     = 300;
    localparam int unsigned HoldCycles = 400;
    localparam int unsigned SettleCyc  = 50;
    localparam int unsigned PrintCap   = 200;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } t_rx_mode;

    logic                            clk;
    logic                            rst_n    = 1'b0;
    logic                            cfg_we   = 1'b0;
    logic [tscond_pkg::CfgIdxW-1:0]  cfg_idx  = '0;
    logic [tscond_pkg::CfgDataW-1:0] cfg_data = '0;

    tscond_in_if  in_if ();
    tscond_out_if out_if ();

    touch_sample_conditioner_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // predictor copy of the registers and pen state
    bit                            swap_q    = 1'b0;
    bit                            flip_x_q  = 1'b0;
    bit                            flip_y_q  = 1'b0;
    bit                            reduce_q  = 1'b1;
    logic [tscond_pkg::PlateW-1:0] plate_q   = '0;
    logic [tscond_pkg::TimerW-1:0] ticks_q   = tscond_pkg::ReleaseTicksRst;
    bit                            pen_q     = 1'b0;
    logic [tscond_pkg::TimerW-1:0] timer_q   = '0;
    bit                            armed_q   = 1'b0;

    tscond_pkg::t_in_word  pending_words[$];
    tscond_pkg::t_out_word expected_reports[$];

    int unsigned in_cnt          = 0;
    int unsigned errors          = 0;
    int unsigned reports_checked = 0;
    int unsigned pressure_seen   = 0;
    int unsigned pen_up_timeouts = 0;
    int unsigned burst_left      = 0;
    int unsigned gap_left        = 0;
    int unsigned hold_left       = 0;
    bit          hold_done       = 1'b0;
    int unsigned mode_left       = 0;
    t_rx_mode    rx_mode         = RX_OPEN;

    function automatic logic [tscond_pkg::CoordW-1:0] map_coord(
        logic [tscond_pkg::CoordW-1:0] v, bit flip);
        logic [tscond_pkg::CoordW-1:0] r;
        r = flip ? (tscond_pkg::CoordMax - v) : v;
        if (reduce_q)
            r = r >> tscond_pkg::ReduceSh;
        return r;
    endfunction

    // advances the pen state for one request; returns 1 when a report is due
    function automatic bit touch_predict(input tscond_pkg::t_in_word w,
                                         output tscond_pkg::t_out_word r);
        logic [tscond_pkg::CoordW-1:0] xv;
        logic [tscond_pkg::CoordW-1:0] yv;
        logic [tscond_pkg::CoordW-1:0] z1v;
        logic [tscond_pkg::CoordW-1:0] z2v;
        logic [tscond_pkg::CoordW-1:0] mv;
        logic [tscond_pkg::ProdW-1:0]  p;
        bit                            any;
        r   = '0;
        any = 1'b0;
        if (w.req_type == tscond_pkg::REQ_TICK) begin
            if (!armed_q)
                return 1'b0;
            if (timer_q > tscond_pkg::TimerW'(1)) begin
                timer_q = timer_q - tscond_pkg::TimerW'(1);
                return 1'b0;
            end
            timer_q = '0;
            armed_q = 1'b0;
            pen_q   = 1'b0;
            r.touch_changed  = 1'b1;
            r.pressure_valid = 1'b1;
            return 1'b1;
        end
        xv  = w.x_ready  ? w.x_sample  : '0;
        yv  = w.y_ready  ? w.y_sample  : '0;
        z1v = w.z1_ready ? w.z1_sample : '0;
        z2v = w.z2_ready ? w.z2_sample : '0;
        armed_q = 1'b0;
        timer_q = '0;
        if (w.pen_is_down != pen_q) begin
            pen_q = w.pen_is_down;
            r.touch_changed = 1'b1;
            any = 1'b1;
        end
        if (w.x_ready) begin
            mv = map_coord(xv, swap_q ? flip_y_q : flip_x_q);
            if (swap_q) begin
                r.axis_y_valid = 1'b1;
                r.axis_y_value = mv;
            end else begin
                r.axis_x_valid = 1'b1;
                r.axis_x_value = mv;
            end
            any = 1'b1;
        end
        if (w.y_ready) begin
            mv = map_coord(yv, swap_q ? flip_x_q : flip_y_q);
            if (swap_q) begin
                r.axis_x_valid = 1'b1;
                r.axis_x_value = mv;
            end else begin
                r.axis_y_valid = 1'b1;
                r.axis_y_value = mv;
            end
            any = 1'b1;
        end
        if (w.x_ready && w.z1_ready && w.z2_ready && xv != '0 && z1v != '0) begin
            // all of it wraps at 32 bits
            p = tscond_pkg::ProdW'(z2v) - tscond_pkg::ProdW'(z1v);
            p = p * tscond_pkg::ProdW'(xv);
            p = p * tscond_pkg::ProdW'(plate_q);
            p = p / tscond_pkg::ProdW'(z1v);
            p = (p + tscond_pkg::ProdW'(tscond_pkg::RoundBias)) >> tscond_pkg::RoundShift;
            if (p <= tscond_pkg::ProdW'(tscond_pkg::PressMax)) begin
                r.pressure_valid = 1'b1;
                r.pressure_value = tscond_pkg::PressW'(
                    tscond_pkg::ProdW'(tscond_pkg::PressMax) - p);
                any = 1'b1;
            end
        end
        r.touch_state = pen_q;
        if (pen_q) begin
            armed_q = 1'b1;
            timer_q = ticks_q;
        end
        return any;
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < PrintCap)
            $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("report %0d %s got %0d want %0d",
                                      reports_checked, name, got, want));
    endtask

    // sender: bursts of words with random gaps
    always @(posedge clk) begin
        tscond_pkg::t_out_word rep;
        if (!rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data  <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                in_cnt <= in_cnt + 1;
                if (touch_predict(in_if.data, rep))
                    expected_reports.push_back(rep);
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left != 0) begin
                    gap_left    <= gap_left - 1;
                    in_if.valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    in_if.valid <= 1'b1;
                    in_if.data  <= pending_words.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off once the stream is well under way
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && in_cnt >= HoldAt) begin
            hold_done <= 1'b1;
            hold_left <= HoldCycles;
        end
    end

    // receiver stall pattern
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            out_if.ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= t_rx_mode'($urandom_range(0, 3));
                mode_left <= $urandom_range(8, 64);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_OPEN:   out_if.ready <= 1'b1;
                RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
                default:   out_if.ready <= ~out_if.ready;
            endcase
        end
    end

    // monitor: every report word against the oldest expectation
    always @(posedge clk) begin
        tscond_pkg::t_out_word want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (expected_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected report %h", out_if.data));
            end else begin
                want = expected_reports.pop_front();
                check_field("touch_state", 32'(out_if.data.touch_state),
                            32'(want.touch_state));
                check_field("touch_changed", 32'(out_if.data.touch_changed),
                            32'(want.touch_changed));
                check_field("axis_x_valid", 32'(out_if.data.axis_x_valid),
                            32'(want.axis_x_valid));
                check_field("axis_x_value", 32'(out_if.data.axis_x_value),
                            32'(want.axis_x_value));
                check_field("axis_y_valid", 32'(out_if.data.axis_y_valid),
                            32'(want.axis_y_valid));
                check_field("axis_y_value", 32'(out_if.data.axis_y_value),
                            32'(want.axis_y_value));
                check_field("pressure_valid", 32'(out_if.data.pressure_valid),
                            32'(want.pressure_valid));
                check_field("pressure_value", 32'(out_if.data.pressure_value),
                            32'(want.pressure_value));
                reports_checked++;
                if (want.pressure_valid && want.pressure_value != '0)
                    pressure_seen++;
                if (want.pressure_valid && !want.touch_state && want.touch_changed &&
                    !want.axis_x_valid && !want.axis_y_valid && want.pressure_value == '0)
                    pen_up_timeouts++;
            end
        end
    end

    function automatic tscond_pkg::t_in_word sample_word(bit pen, bit [3:0] rdy,
                                                         logic [tscond_pkg::CoordW-1:0] x,
                                                         logic [tscond_pkg::CoordW-1:0] y,
                                                         logic [tscond_pkg::CoordW-1:0] z1,
                                                         logic [tscond_pkg::CoordW-1:0] z2);
        tscond_pkg::t_in_word w;
        w.req_type    = tscond_pkg::REQ_SAMPLE;
        w.pen_is_down = pen;
        {w.x_ready, w.y_ready, w.z1_ready, w.z2_ready} = rdy;
        w.x_sample  = x;
        w.y_sample  = y;
        w.z1_sample = z1;
        w.z2_sample = z2;
        return w;
    endfunction

    function automatic tscond_pkg::t_in_word noise_word();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return tscond_pkg::t_in_word'(raw[$bits(tscond_pkg::t_in_word)-1:0]);
    endfunction

    function automatic tscond_pkg::t_in_word tick_word();
        tscond_pkg::t_in_word w;
        w = noise_word();
        w.req_type = tscond_pkg::REQ_TICK;
        return w;
    endfunction

    function automatic logic [tscond_pkg::CoordW-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return tscond_pkg::CoordMax;
            default: return tscond_pkg::CoordW'($urandom);
        endcase
    endfunction

    function automatic bit [3:0] rand_ready(int unsigned pct);
        bit [3:0] r;
        for (int i = 0; i < 4; i++)
            r[i] = ($urandom_range(1, 100) <= pct);
        return r;
    endfunction

    // waits for the block to drain, then for any word still in flight without a report
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_if.valid || expected_reports.size() != 0);
        repeat (SettleCyc) @(posedge clk);
    endtask

    task automatic cfg_write(input tscond_pkg::t_cfg_reg idx,
                             input logic [tscond_pkg::CfgDataW-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            tscond_pkg::CFG_SWAP_AXES:     swap_q   = data[0];
            tscond_pkg::CFG_FLIP_X:        flip_x_q = data[0];
            tscond_pkg::CFG_FLIP_Y:        flip_y_q = data[0];
            tscond_pkg::CFG_REDUCE_8BIT:   reduce_q = data[0];
            tscond_pkg::CFG_PLATE_RES:     plate_q  = data[tscond_pkg::PlateW-1:0];
            tscond_pkg::CFG_RELEASE_TICKS: ticks_q  = data[tscond_pkg::TimerW-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input bit swap, input bit fx, input bit fy, input bit red,
                                  input logic [tscond_pkg::PlateW-1:0] plate,
                                  input logic [tscond_pkg::TimerW-1:0] ticks);
        wait_idle();
        cfg_write(tscond_pkg::CFG_SWAP_AXES, tscond_pkg::CfgDataW'(swap));
        cfg_write(tscond_pkg::CFG_FLIP_X, tscond_pkg::CfgDataW'(fx));
        cfg_write(tscond_pkg::CFG_FLIP_Y, tscond_pkg::CfgDataW'(fy));
        cfg_write(tscond_pkg::CFG_REDUCE_8BIT, tscond_pkg::CfgDataW'(red));
        cfg_write(tscond_pkg::CFG_PLATE_RES, plate);
        cfg_write(tscond_pkg::CFG_RELEASE_TICKS, ticks);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic gen_random_words(input int unsigned n);
        int unsigned cnt;
        int unsigned kind;
        int unsigned run;
        logic [tscond_pkg::CoordW-1:0] z1;
        logic [tscond_pkg::CoordW-1:0] z2;
        cnt = 0;
        while (cnt < n) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                // pen down with mostly complete conversions
                if ($urandom_range(0, 1)) begin
                    z1 = tscond_pkg::CoordW'($urandom_range(200, 2000));
                    z2 = tscond_pkg::CoordW'(z1 + $urandom_range(0, tscond_pkg::CoordMax - z1));
                end else begin
                    z1 = rand_coord();
                    z2 = rand_coord();
                end
                pending_words.push_back(sample_word(1'b1, rand_ready(90), rand_coord(),
                                                    rand_coord(), z1, z2));
                cnt++;
            end else if (kind < 65) begin
                run = $urandom_range(1, 8);
                repeat (run) pending_words.push_back(tick_word());
                cnt += run;
            end else if (kind < 80) begin
                pending_words.push_back(sample_word(1'b0, rand_ready(50), rand_coord(),
                                                    rand_coord(), rand_coord(), rand_coord()));
                cnt++;
            end else begin
                pending_words.push_back(noise_word());
                cnt++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: no swap, no flips, 8-bit reduction, zero plate
        pending_words.push_back(sample_word(1'b1, 4'b1111, tscond_pkg::CoordMax, '0, 12'd1,
                                            tscond_pkg::CoordMax));
        pending_words.push_back(sample_word(1'b1, 4'b1111, '0, tscond_pkg::CoordMax,
                                            tscond_pkg::CoordMax, '0));
        pending_words.push_back(sample_word(1'b1, 4'b1111, 12'd2048, 12'd5, '0, 12'd900));
        pending_words.push_back(sample_word(1'b1, 4'b0000, 12'd7, 12'd7, 12'd7, 12'd7));
        pending_words.push_back(tick_word());
        pending_words.push_back(sample_word(1'b0, 4'b0000, '0, '0, '0, '0));
        pending_words.push_back(tick_word());
        pending_words.push_back(sample_word(1'b0, 4'b1000, 12'd1234, '0, '0, '0));
        pending_words.push_back(sample_word(1'b0, 4'b0100, '0, 12'd3210, '0, '0));
        pending_words.push_back(sample_word(1'b1, 4'b1010, 12'd1500, 12'd800, 12'd300, 12'd0));

        // swapped, x flipped, full width, largest plate, zero release ticks
        apply_settings(1'b1, 1'b1, 1'b0, 1'b0, 16'hffff, 16'd0);
        pending_words.push_back(sample_word(1'b1, 4'b1111, tscond_pkg::CoordMax, '0,
                                            tscond_pkg::CoordMax, tscond_pkg::CoordMax));
        pending_words.push_back(tick_word());
        pending_words.push_back(tick_word());
        pending_words.push_back(sample_word(1'b1, 4'b1111, tscond_pkg::CoordMax,
                                            tscond_pkg::CoordMax, 12'd1,
                                            tscond_pkg::CoordMax));
        pending_words.push_back(sample_word(1'b1, 4'b1111, 12'd100, 12'd50, 12'd2000, 12'd100));
        pending_words.push_back(sample_word(1'b1, 4'b1111, 12'd1, 12'd1, tscond_pkg::CoordMax,
                                            tscond_pkg::CoordMax));
        pending_words.push_back(tick_word());

        // both flips, 8-bit, modest plate, timer restart
        apply_settings(1'b0, 1'b1, 1'b1, 1'b1, 16'd400, 16'd2);
        pending_words.push_back(sample_word(1'b1, 4'b1111, 12'd3000, 12'd1000, 12'd500,
                                            12'd1500));
        pending_words.push_back(tick_word());
        pending_words.push_back(sample_word(1'b1, 4'b0000, '0, '0, '0, '0));
        pending_words.push_back(tick_word());
        pending_words.push_back(tick_word());
        pending_words.push_back(sample_word(1'b0, 4'b1111, 12'd2000, 12'd2000, 12'd800,
                                            12'd1600));
        pending_words.push_back(sample_word(1'b1, 4'b1011, tscond_pkg::CoordMax, '0, 12'd100,
                                            12'd4000));
        pending_words.push_back(tick_word());
        pending_words.push_back(tick_word());

        apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       tscond_pkg::PlateW'($urandom_range(50, 800)),
                       tscond_pkg::TimerW'($urandom_range(1, 6)));
        gen_random_words(160);
        apply_settings(1'b1, 1'b0, 1'b1, 1'b0, 16'hffff, 16'd1);
        gen_random_words(160);
        apply_settings(1'b0, 1'b0, 1'b0, 1'b1, 16'd0, 16'hffff);
        gen_random_words(160);
        apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       tscond_pkg::PlateW'($urandom),
                       tscond_pkg::TimerW'($urandom_range(1, 12)));
        gen_random_words(160);
        apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       tscond_pkg::PlateW'($urandom_range(100, 3000)),
                       tscond_pkg::TimerW'($urandom_range(2, 8)));
        gen_random_words(160);

        wait_idle();
        $display("run covered %0d request words and %0d checked reports", in_cnt,
                 reports_checked);
        $display("reports with nonzero pressure %0d, pen-up timeouts %0d, mismatches %0d",
                 pressure_seen, pen_up_timeouts, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d reports outstanding", expected_reports.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tscond_pkg.sv
rtl/tscond_in_if.sv
rtl/tscond_out_if.sv
rtl/tscond_ctrl.sv
rtl/tscond_datapath.sv
rtl/touch_sample_conditioner_unit.sv
sim/testbench.sv
